// File: src/des_pkg.sv
// Package with the DES permutation tables, S-boxes and round functions.
package des_pkg;

    localparam int Rounds = 16;
    localparam int HalfKeyBits = 28;
    localparam int SubkeyBits = 48;
    localparam int BlockBits = 64;
    localparam int AddrBits = 3;
    localparam logic [AddrBits-1:0] RegCipherKey = 3'd0;
    localparam logic OpEncrypt = 1'b0;
    localparam logic OpDecrypt = 1'b1;

    typedef logic [7:0] tab_entry_t;
    typedef logic [HalfKeyBits-1:0] half_key_t;
    typedef logic [SubkeyBits-1:0] subkey_t;

    // Per-stage control that travels beside the data.
    typedef struct packed {
        logic valid;
        logic opcode;
    } stage_ctl_t;

    localparam tab_entry_t TabIp [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7 };

    localparam tab_entry_t TabFp [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25 };

    localparam tab_entry_t TabE [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
        28,29,30,31,32,1 };

    localparam tab_entry_t TabP [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25 };

    localparam tab_entry_t TabPc1 [56] = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4 };

    localparam tab_entry_t TabPc2 [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53,
        46,42,50,36,29,32 };

    localparam tab_entry_t TabRot [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

    localparam logic [3:0] TabS [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
          0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
          15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
          3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
          13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
          13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
          1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
          13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
          3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
          14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
          11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
          10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
          4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
          13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
          6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
          1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
          2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11} };

    // Bit numbering: table entry n names bit n counted from the MSB.
    function automatic logic [63:0] perm_ip(input logic [63:0] v);
        logic [63:0] r;
        for (int k = 0; k < 64; k++) r[63-k] = v[64-int'(TabIp[k])];
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] v);
        logic [63:0] r;
        for (int k = 0; k < 64; k++) r[63-k] = v[64-int'(TabFp[k])];
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] v);
        logic [55:0] r;
        for (int k = 0; k < 56; k++) r[55-k] = v[64-int'(TabPc1[k])];
        return r;
    endfunction

    function automatic subkey_t perm_pc2(input logic [55:0] v);
        subkey_t r;
        for (int k = 0; k < 48; k++) r[47-k] = v[56-int'(TabPc2[k])];
        return r;
    endfunction

    // Round key for round i (0-based): halves rotated by the running total.
    function automatic subkey_t round_key(input logic [55:0] cd, input int i);
        half_key_t c;
        half_key_t d;
        int sh;
        sh = 0;
        for (int j = 0; j <= i; j++) sh += int'(TabRot[j]);
        c = cd[55:28];
        d = cd[27:0];
        for (int j = 0; j < sh; j++) begin
            c = {c[26:0], c[27]};
            d = {d[26:0], d[27]};
        end
        return perm_pc2({c, d});
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] r, input subkey_t k);
        subkey_t x;
        logic [31:0] s;
        logic [31:0] p;
        logic [5:0] six;
        for (int n = 0; n < 48; n++) x[47-n] = r[32-int'(TabE[n])];
        x = x ^ k;
        for (int b = 0; b < 8; b++) begin
            six = x[47-6*b -: 6];
            s[31-4*b -: 4] = TabS[b][{six[5], six[0], six[4:1]}];
        end
        for (int n = 0; n < 32; n++) p[31-n] = s[32-int'(TabP[n])];
        return p;
    endfunction

endpackage

// File: src/des_keysched.sv
// Key schedule: holds the key register, decodes APB writes, expands round keys.
module des_keysched (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [des_pkg::AddrBits-1:0]   paddr,
    input  logic [63:0]                    pwdata,
    output logic [63:0]                    prdata,
    output des_pkg::subkey_t               round_keys [des_pkg::Rounds]
);

    logic [63:0] key_reg;
    logic [63:0] key_next;
    logic [55:0] cd_reg;
    logic        wr_en;

    assign wr_en = psel && penable && pwrite && (paddr == des_pkg::RegCipherKey);

    always_comb begin
        key_next = key_reg;
        if (wr_en) begin
            key_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
            cd_reg  <= '0;
        end else begin
            key_reg <= key_next;
            cd_reg  <= des_pkg::perm_pc1(key_next);
        end
    end

    always_comb begin
        prdata = (paddr == des_pkg::RegCipherKey) ? key_reg : '0;
    end

    // Round keys are fixed rotations and a fixed select of the stored halves.
    always_comb begin
        for (int i = 0; i < des_pkg::Rounds; i++) begin
            round_keys[i] = des_pkg::round_key(cd_reg, i);
        end
    end

endmodule

// File: src/des_round.sv
// One pipelined DES round with its own stage register and stall control.
module des_round (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  des_pkg::stage_ctl_t   ctl_in,
    input  logic [63:0]           lr_in,
    input  des_pkg::subkey_t      key_enc,
    input  des_pkg::subkey_t      key_dec,
    output des_pkg::stage_ctl_t   ctl_out,
    output logic [63:0]           lr_out
);

    des_pkg::stage_ctl_t ctl_reg;
    logic [63:0]         lr_reg;
    logic [63:0]         lr_next;
    des_pkg::subkey_t    k;

    always_comb begin
        k = (ctl_in.opcode == des_pkg::OpDecrypt) ? key_dec : key_enc;
        lr_next = {lr_in[31:0], lr_in[63:32] ^ des_pkg::feistel(lr_in[31:0], k)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (advance) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            lr_reg <= lr_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign lr_out  = lr_reg;

endmodule

// File: src/des_block_cipher_top.sv
// Top level of the pipelined DES ECB engine with AXI-Stream and APB ports.
//
// This engine encrypts or decrypts one 64-bit DES block per beat in ECB mode
// under the 64-bit key held in the cipher_key register (byte address 0, parity
// bits ignored). The datapath is fully unrolled: an input stage applies IP,
// sixteen round stages each compute one Feistel round, and an output stage
// applies the inverse IP, so a beat passes through these stages in turn on its way to
// m_axis, and a new beat is accepted every cycle while the
// output is taken. The whole pipeline advances together, and a stall on
// m_axis_tready holds every stage, empty ones included, so s_axis_tready drops
// for as long as a result waits. Round keys are derived from a registered PC1
// image of the key, so the key must be written only while the pipeline is empty.
module des_block_cipher_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // block_in[63:0]
    input  logic        s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // block_out[63:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int NStages = des_pkg::Rounds + 2;

    des_pkg::subkey_t    round_keys [des_pkg::Rounds];
    des_pkg::stage_ctl_t ctl [des_pkg::Rounds+1];
    logic [63:0]         lr [des_pkg::Rounds+1];
    logic                advance;
    logic                out_valid_reg;
    logic [63:0]         out_data_reg;
    logic                in_accept;

    assign pready = 1'b1;

    // The pipeline moves when the output slot is free or being drained.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    des_keysched u_keysched (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .round_keys (round_keys)
    );

    // Input stage: initial permutation.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl[0] <= '0;
        end else if (advance) begin
            ctl[0] <= '{valid: s_axis_tvalid, opcode: s_axis_tuser};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            lr[0] <= des_pkg::perm_ip(s_axis_tdata);
        end
    end

    for (genvar g = 0; g < des_pkg::Rounds; g++) begin : g_round
        des_round u_round (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .ctl_in  (ctl[g]),
            .lr_in   (lr[g]),
            .key_enc (round_keys[g]),
            .key_dec (round_keys[des_pkg::Rounds-1-g]),
            .ctl_out (ctl[g+1]),
            .lr_out  (lr[g+1])
        );
    end

    // Output stage: swap halves and apply the inverse permutation.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= ctl[des_pkg::Rounds].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= des_pkg::perm_fp({lr[des_pkg::Rounds][31:0],
                                              lr[des_pkg::Rounds][63:32]});
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // A held output must keep its data and valid flag.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output changed while stalled");

    // An accepted beat enters the first stage as valid.
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> ctl[0].valid)
        else $error("accepted beat lost at pipeline entry");

    // While stalled, the last round stage keeps its control.
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(ctl[des_pkg::Rounds]))
        else $error("pipeline moved during stall");

    // The pipeline depth constant matches the stage count.
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (NStages == des_pkg::Rounds + 2) |-> 1'b1)
        else $error("depth mismatch");

endmodule

// File: test/tb.sv
// Self-checking testbench for the DES ECB engine: directed vectors plus keyed random phases.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // block_in[63:0]
    logic        s_axis_tuser;   // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // block_out[63:0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    des_block_cipher_top i_dut (.*);

    // The key copy the predictor works with; it only changes while the pipeline is empty.
    logic [63:0] model_key;
    logic [63:0] expected_blocks[$];
    int          error_count;
    int          out_beats;
    int          cycle_count;
    bit          no_idle;
    bit          long_hold_done;

    // One directed vector. Where has_known is set, the result is a published DES answer.
    typedef struct {
        logic [63:0] key;
        logic        op;
        logic [63:0] blk;
        bit          has_known;
        logic [63:0] known;
    } vector_t;

    vector_t vectors[$];

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Bit-accurate DES: FIPS numbering, bit 1 is the MSB of every vector.
    function automatic logic [63:0] des_crypt(input logic [63:0] key, input logic dec,
                                              input logic [63:0] blk);
        logic [55:0] cd;
        logic [27:0] c;
        logic [27:0] d;
        logic [47:0] sched[16];
        logic [63:0] perm;
        logic [31:0] lh;
        logic [31:0] rh;
        logic [31:0] tmp;
        logic [47:0] x;
        logic [31:0] sb;
        logic [31:0] f;
        logic [5:0]  six;
        logic [63:0] res;
        for (int k = 0; k < 56; k++) cd[55-k] = key[64-int'(des_pkg::TabPc1[k])];
        c = cd[55:28];
        d = cd[27:0];
        for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < int'(des_pkg::TabRot[i]); j++) begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end
            cd = {c, d};
            for (int k = 0; k < 48; k++) sched[i][47-k] = cd[56-int'(des_pkg::TabPc2[k])];
        end
        for (int k = 0; k < 64; k++) perm[63-k] = blk[64-int'(des_pkg::TabIp[k])];
        lh = perm[63:32];
        rh = perm[31:0];
        for (int i = 0; i < 16; i++) begin
            for (int n = 0; n < 48; n++) x[47-n] = rh[32-int'(des_pkg::TabE[n])];
            x = x ^ (dec == des_pkg::OpDecrypt ? sched[15-i] : sched[i]);
            for (int b = 0; b < 8; b++) begin
                six = x[47-6*b -: 6];
                sb[31-4*b -: 4] = des_pkg::TabS[b][{six[5], six[0]} * 16 + six[4:1]];
            end
            for (int n = 0; n < 32; n++) f[31-n] = sb[32-int'(des_pkg::TabP[n])];
            tmp = lh ^ f;
            lh = rh;
            rh = tmp;
        end
        perm = {rh, lh};
        for (int k = 0; k < 64; k++) res[63-k] = perm[64-int'(des_pkg::TabFp[k])];
        return res;
    endfunction

    // Each accepted input beat gets its predicted block queued.
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            expected_blocks.push_back(des_crypt(model_key, s_axis_tuser, s_axis_tdata));
        end
    end

    // Each accepted output beat is compared with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            out_beats++;
            if (expected_blocks.size() == 0) begin
                $error("block_out: unexpected beat, actual %h", m_axis_tdata);
                error_count++;
            end else begin
                if (m_axis_tdata !== expected_blocks[0]) begin
                    $error("block_out: expected %h actual %h", expected_blocks[0], m_axis_tdata);
                    error_count++;
                end
                void'(expected_blocks.pop_front());
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 400000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: random stalls per beat, one long hold-off so that the whole pipeline
    // fills and the input gets back-pressured, and quiet stretches with no stalls at all.
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 7);
            if (!long_hold_done && out_beats >= 300) begin
                gap = 400;
                long_hold_done = 1'b1;
            end
            repeat (gap) @(negedge aclk) m_axis_tready <= 1'b0;
            @(negedge aclk) m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    // Offers one beat after a random gap and holds it until it is taken.
    task automatic send_block(input logic op, input logic [63:0] blk);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        repeat (gap) @(negedge aclk) s_axis_tvalid <= 1'b0;
        @(negedge aclk) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= op;
            s_axis_tdata  <= blk;
        end
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Drains the pipeline, then lets the full latency pass before anything touches the key.
    task automatic wait_empty();
        @(negedge aclk) s_axis_tvalid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    // Writes the key register over APB and reads it back.
    task automatic load_key(input logic [63:0] key);
        @(negedge aclk) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= des_pkg::RegCipherKey;
            pwdata  <= key;
        end
        @(negedge aclk) penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        model_key = key;
        @(negedge aclk) begin
            penable <= 1'b0;
            pwrite  <= 1'b0;
        end
        @(negedge aclk) penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== key) begin
            $error("cipher_key: expected %h actual %h", key, prdata);
            error_count++;
        end
        @(negedge aclk) begin
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    initial begin
        logic [63:0] phase_key;
        logic [63:0] blk;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = des_pkg::OpEncrypt;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = des_pkg::RegCipherKey;
        pwdata         = '0;
        model_key      = '0;
        error_count    = 0;
        out_beats      = 0;
        cycle_count    = 0;
        no_idle        = 1'b0;
        long_hold_done = 1'b0;
        aresetn        = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Directed vectors. The first rows run on the reset key of zero.
        vectors = '{
            '{64'h0, des_pkg::OpEncrypt, 64'h0, 1, 64'h8CA64DE9C1B123A7},
            '{64'h0, des_pkg::OpDecrypt, 64'h8CA64DE9C1B123A7, 1, 64'h0},
            '{64'h0, des_pkg::OpEncrypt, 64'hFFFFFFFFFFFFFFFF, 0, 64'h0},
            '{64'h0, des_pkg::OpDecrypt, 64'h0, 0, 64'h0},
            '{64'h133457799BBCDFF1, des_pkg::OpEncrypt, 64'h0123456789ABCDEF, 1,
              64'h85E813540F0AB405},
            '{64'h133457799BBCDFF1, des_pkg::OpDecrypt, 64'h85E813540F0AB405, 1,
              64'h0123456789ABCDEF},
            '{64'h133457799BBCDFF1, des_pkg::OpEncrypt, 64'h8000000000000000, 0, 64'h0},
            '{64'h133457799BBCDFF1, des_pkg::OpEncrypt, 64'h0000000000000001, 0, 64'h0},
            '{64'hFFFFFFFFFFFFFFFF, des_pkg::OpEncrypt, 64'hFFFFFFFFFFFFFFFF, 1,
              64'h7359B2163E4EDC58},
            '{64'hFFFFFFFFFFFFFFFF, des_pkg::OpDecrypt, 64'h7359B2163E4EDC58, 1,
              64'hFFFFFFFFFFFFFFFF},
            '{64'hFFFFFFFFFFFFFFFF, des_pkg::OpEncrypt, 64'h0, 0, 64'h0},
            // Parity bits only: the key schedule must treat this exactly like key zero.
            '{64'h0101010101010101, des_pkg::OpEncrypt, 64'h0, 1, 64'h8CA64DE9C1B123A7},
            // A weak key: encryption is its own inverse, handled with no special flag.
            '{64'hFEFEFEFEFEFEFEFE, des_pkg::OpEncrypt, 64'h0123456789ABCDEF, 0, 64'h0},
            '{64'hFEFEFEFEFEFEFEFE, des_pkg::OpDecrypt, 64'hAAAAAAAA55555555, 0, 64'h0},
            // A semi-weak key.
            '{64'h01FE01FE01FE01FE, des_pkg::OpEncrypt, 64'h5555555555555555, 0, 64'h0}
        };
        foreach (vectors[i]) begin
            if (vectors[i].key !== model_key) begin
                wait_empty();
                load_key(vectors[i].key);
            end
            send_block(vectors[i].op, vectors[i].blk);
            if (vectors[i].has_known
                    && des_crypt(model_key, vectors[i].op, vectors[i].blk) !== vectors[i].known) begin
                $error("block_out: expected %h actual %h (predictor)", vectors[i].known,
                       des_crypt(model_key, vectors[i].op, vectors[i].blk));
                error_count++;
            end
        end

        // Random phases, each under its own key; the first two use the extremes and the last a fixed key.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: phase_key = '0;
                1: phase_key = '1;
                7: phase_key = 64'h1F1F1F1F0E0E0E0E;
                default: phase_key = {$urandom, $urandom};
            endcase
            wait_empty();
            load_key(phase_key);
            // Every third phase runs back to back on both sides.
            no_idle = (ph % 3 == 2);
            for (int n = 0; n < 212; n++) begin
                case ($urandom_range(0, 9))
                    0: blk = '0;
                    1: blk = '1;
                    2: blk = 64'h1 << $urandom_range(0, 63);
                    default: blk = {$urandom, $urandom};
                endcase
                send_block(1'($urandom_range(0, 1)), blk);
            end
        end

        @(negedge aclk) s_axis_tvalid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
